// ----- hw/rtl/gnm_pkg.sv -----
// ============================================================================
// gnm_pkg - shared types and constants for the neighbor membership table
// Holds sizes, register indexes, operation codes, status codes and the
// front-to-back command record.
// ============================================================================
package gnm_pkg;

    localparam int MAX_CELLS_DEF     = 256;
    localparam int CELL_CAPACITY_DEF = 4;
    localparam int ID_BITS_DEF       = 16;
    localparam int COORD_BITS_DEF    = 16;
    localparam int MAX_RESULTS       = 36;
    localparam int MAX_GRID_DIM      = 16;
    localparam int IDW               = 16;
    localparam int CW                = 16;

    localparam logic [2:0] REG_X_ORIGIN     = 3'd0;
    localparam logic [2:0] REG_CELL_WIDTH   = 3'd1;
    localparam logic [2:0] REG_CELLS_ACROSS = 3'd2;
    localparam logic [2:0] REG_Y_ORIGIN     = 3'd3;
    localparam logic [2:0] REG_CELL_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_CELLS_DOWN   = 3'd5;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    // Command passed from the front to the back through the queue.
    typedef struct packed {
        logic [1:0]     func;
        logic [IDW-1:0] id;
        logic           outside;
        logic [3:0]     col;
        logic [3:0]     row;
        logic [4:0]     across;
        logic [4:0]     down;
    } t_cmd;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CELL,
        BS_FILL,
        BS_READ,
        BS_EMIT,
        BS_WRITE,
        BS_DONE
    } t_back_state;

endpackage

// ----- hw/rtl/gnm_ram.sv -----
// ============================================================================
// gnm_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module gnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/gnm_front.sv -----
// ============================================================================
// gnm_front - locate an item's cell
// Clamp the grid, then find column and row by restoring division, one
// quotient bit of each per cycle; push the command into the queue.
// ============================================================================
module gnm_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [1:0]              i_func,
    input  logic [gnm_pkg::IDW-1:0] i_member_id,
    input  logic signed [15:0]      i_pos_x,
    input  logic signed [15:0]      i_pos_y,
    input  logic signed [15:0]      i_x_origin,
    input  logic [15:0]             i_cell_width,
    input  logic [4:0]              i_cells_across,
    input  logic signed [15:0]      i_y_origin,
    input  logic [15:0]             i_cell_height,
    input  logic [4:0]              i_cells_down,
    input  logic                    i_q_full,
    output logic                    o_busy,
    output logic                    o_push,
    output gnm_pkg::t_cmd           o_cmd
);
    gnm_pkg::t_front_state r_state, n_state;
    logic [4:0]  r_cnt;
    logic [16:0] r_remx, r_remy, r_dx, r_dy;
    logic [16:0] r_qx, r_qy;
    logic [15:0] r_w, r_h;
    logic        r_neg;
    logic [1:0]  r_func;
    logic [15:0] r_id;
    logic [4:0]  r_across, r_down;

    logic signed [16:0] w_dx, w_dy;
    logic [17:0] w_tx, w_ty;
    logic [4:0]  w_ac, w_dn;
    logic [8:0]  w_cell;
    logic        w_out;

    assign w_dx = 17'(i_pos_x) - 17'(i_x_origin);
    assign w_dy = 17'(i_pos_y) - 17'(i_y_origin);
    assign w_ac = (i_cells_across == 5'd0) ? 5'd1 :
                  (i_cells_across > 5'd16) ? 5'd16 : i_cells_across;
    assign w_dn = (i_cells_down == 5'd0) ? 5'd1 :
                  (i_cells_down > 5'd16) ? 5'd16 : i_cells_down;
    assign w_tx = {r_remx, r_dx[16]} - {2'b0, r_w};
    assign w_ty = {r_remy, r_dy[16]} - {2'b0, r_h};
    assign w_cell = 9'(r_qy[4:0]) * 9'(r_across) + 9'(r_qx[4:0]);
    assign w_out = r_neg || (r_qx >= 17'(r_across)) || (r_qy >= 17'(r_down))
                   || (w_cell >= 9'd256);

    always_comb begin
        n_state = r_state;
        case (r_state)
            gnm_pkg::FS_IDLE: if (i_start) n_state = gnm_pkg::FS_DIV;
            gnm_pkg::FS_DIV:  if (r_cnt == 5'd16) n_state = gnm_pkg::FS_PUSH;
            gnm_pkg::FS_PUSH: if (!i_q_full) n_state = gnm_pkg::FS_IDLE;
            default:          n_state = gnm_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        o_busy = 1'b1;
        o_push = 1'b0;
        case (r_state)
            gnm_pkg::FS_IDLE: o_busy = 1'b0;
            gnm_pkg::FS_PUSH: o_push = !i_q_full;
            default:          o_busy = 1'b1;
        endcase
    end

    always_comb begin
        o_cmd.func    = r_func;
        o_cmd.id      = r_id;
        o_cmd.outside = w_out;
        o_cmd.col     = r_qx[3:0];
        o_cmd.row     = r_qy[3:0];
        o_cmd.across  = r_across;
        o_cmd.down    = r_down;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gnm_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == gnm_pkg::FS_IDLE) begin
            // Pre-shift the dividends so 16 steps consume bits 15..0.
            r_cnt    <= 5'd0;
            r_dx     <= {w_dx[15:0], 1'b0};
            r_dy     <= {w_dy[15:0], 1'b0};
            r_remx   <= 17'd0;
            r_remy   <= 17'd0;
            r_qx     <= 17'd0;
            r_qy     <= 17'd0;
            r_neg    <= w_dx[16] || w_dy[16];
            r_w      <= (i_cell_width == 16'd0) ? 16'd1 : i_cell_width;
            r_h      <= (i_cell_height == 16'd0) ? 16'd1 : i_cell_height;
            r_func   <= i_func;
            r_id     <= i_member_id;
            r_across <= w_ac;
            r_down   <= w_dn;
        end else if (r_state == gnm_pkg::FS_DIV && r_cnt != 5'd16) begin
            r_cnt <= r_cnt + 5'd1;
            r_dx  <= {r_dx[15:0], 1'b0};
            r_dy  <= {r_dy[15:0], 1'b0};
            if (!w_tx[17]) begin
                r_remx <= w_tx[16:0];
                r_qx   <= {r_qx[15:0], 1'b1};
            end else begin
                r_remx <= {r_remx[15:0], r_dx[16]};
                r_qx   <= {r_qx[15:0], 1'b0};
            end
            if (!w_ty[17]) begin
                r_remy <= w_ty[16:0];
                r_qy   <= {r_qy[15:0], 1'b1};
            end else begin
                r_remy <= {r_remy[15:0], r_dy[16]};
                r_qy   <= {r_qy[15:0], 1'b0};
            end
        end
    end

    // A push comes only after the division has finished.
    a_push_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_cnt == 5'd16) else $error("push before division done");
    a_busy_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_busy) else $error("push while idle");
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> r_state == gnm_pkg::FS_DIV)
        else $error("start not taken");
endmodule

// ----- hw/rtl/gnm_back.sv -----
// ============================================================================
// gnm_back - carry out add, remove and query on the cell store
// Sequencer over the nine neighbor cells; fill counts in a small RAM with
// per-cell valid bits, ids in a RAM read one entry per cycle.
// ============================================================================
module gnm_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  gnm_pkg::t_cmd           i_cmd,
    output logic                    o_pop,
    output logic                    o_idle,
    output logic [gnm_pkg::IDW-1:0] o_found_id,
    output logic                    o_has_id,
    output logic [1:0]              o_status,
    output logic                    o_last,
    output logic                    o_strobe
);
    gnm_pkg::t_back_state r_state, n_state;
    gnm_pkg::t_cmd r_cmd;
    logic [255:0] r_fv;
    logic [3:0]  r_nb;       // neighbor index 0..8
    logic [7:0]  r_cell;
    logic [2:0]  r_n, r_i, r_k;
    logic [5:0]  r_count;
    logic        r_rd;       // read data valid this cycle
    logic        r_anyhit;
    logic [15:0] r_hit;
    logic [1:0]  r_status_q;

    logic        w_we;
    logic [9:0]  w_waddr, w_raddr;
    logic [15:0] w_wdata, w_rdata;
    logic signed [5:0] w_r, w_c;
    logic [1:0]  w_dro, w_dco;
    logic        w_inb;
    logic [8:0]  w_nc;
    logic [2:0]  w_fill;
    logic        w_fwe;
    logic [2:0]  w_fwdata, w_frdata;
    logic [7:0]  w_fraddr;
    logic        w_rd_end, w_hit;

    gnm_ram #(.WIDTH(16), .DEPTH(1024)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata));

    gnm_ram #(.WIDTH(3), .DEPTH(256)) u_fill (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(r_cell), .i_wdata(w_fwdata),
        .i_raddr(w_fraddr), .o_rdata(w_frdata));

    // Neighbor offsets: index 0 is bottom-right, 8 is top-left.
    always_comb begin
        w_dro = (r_nb < 4'd3) ? 2'd0 : ((r_nb < 4'd6) ? 2'd1 : 2'd2);
        w_dco = 2'(r_nb - 4'd3 * 4'(w_dro));
        w_r = 6'(r_cmd.row) + 6'sd1 - 6'(w_dro);
        w_c = 6'(r_cmd.col) + 6'sd1 - 6'(w_dco);
        w_inb = (w_r >= 0) && (w_c >= 0) && (w_r < 6'(r_cmd.down))
                && (w_c < 6'(r_cmd.across));
        w_nc = 9'(w_r[4:0]) * 9'(r_cmd.across) + 9'(w_c[4:0]);
        if (w_nc >= 9'd256) w_inb = 1'b0;
    end

    // Fetch the fill count while the cell is chosen; it is ready in BS_FILL.
    assign w_fraddr = (r_cmd.func == gnm_pkg::FUNC_QUERY) ? w_nc[7:0] : r_cell;
    assign w_fill   = r_fv[r_cell] ? w_frdata : 3'd0;
    assign w_rd_end = (r_state == gnm_pkg::BS_READ) && (r_i == r_n) && !r_rd;
    assign w_fwe    = (r_state == gnm_pkg::BS_WRITE) ||
                      (w_rd_end && r_cmd.func == gnm_pkg::FUNC_REMOVE);
    assign w_fwdata = (r_state == gnm_pkg::BS_WRITE) ? r_n + 3'd1 : r_k;
    assign w_hit    = (r_state == gnm_pkg::BS_READ) && r_rd &&
                      (r_cmd.func != gnm_pkg::FUNC_REMOVE) &&
                      (r_count != 6'(gnm_pkg::MAX_RESULTS));

    assign w_raddr = {r_cell, r_i[1:0]};
    assign w_we    = (r_state == gnm_pkg::BS_WRITE) ||
                     (r_state == gnm_pkg::BS_READ && r_rd &&
                      r_cmd.func == gnm_pkg::FUNC_REMOVE && w_rdata != r_cmd.id);
    assign w_waddr = (r_state == gnm_pkg::BS_WRITE) ? {r_cell, r_n[1:0]}
                                                    : {r_cell, r_k[1:0]};
    assign w_wdata = (r_state == gnm_pkg::BS_WRITE) ? r_cmd.id : w_rdata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gnm_pkg::BS_IDLE: if (i_valid) n_state = gnm_pkg::BS_CELL;
            gnm_pkg::BS_CELL: begin
                if (r_cmd.outside || r_cmd.func == gnm_pkg::FUNC_NOP)
                    n_state = gnm_pkg::BS_DONE;
                else if (r_cmd.func == gnm_pkg::FUNC_QUERY && !w_inb) begin
                    if (r_nb == 4'd8) n_state = gnm_pkg::BS_DONE;
                end else n_state = gnm_pkg::BS_FILL;
            end
            gnm_pkg::BS_FILL: begin
                if (r_cmd.func == gnm_pkg::FUNC_ADD)
                    n_state = (w_fill >= 3'd4) ? gnm_pkg::BS_DONE : gnm_pkg::BS_WRITE;
                else n_state = gnm_pkg::BS_READ;
            end
            gnm_pkg::BS_READ: begin
                if (r_i == r_n && !r_rd) begin
                    if (r_cmd.func == gnm_pkg::FUNC_QUERY && r_nb != 4'd8)
                        n_state = gnm_pkg::BS_CELL;
                    else n_state = gnm_pkg::BS_DONE;
                end
            end
            gnm_pkg::BS_WRITE: n_state = gnm_pkg::BS_DONE;
            gnm_pkg::BS_DONE:  n_state = gnm_pkg::BS_IDLE;
            default:           n_state = gnm_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        o_idle = 1'b0;
        case (r_state)
            gnm_pkg::BS_IDLE: begin
                o_pop  = i_valid;
                o_idle = 1'b1;
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gnm_pkg::BS_IDLE;
            r_fv     <= '0;
            r_count  <= 6'd0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (w_hit && r_anyhit) || (r_state == gnm_pkg::BS_DONE);
            if (w_fwe) r_fv[r_cell] <= 1'b1;
            case (r_state)
                gnm_pkg::BS_IDLE: begin
                    r_cmd    <= i_cmd;
                    r_nb     <= 4'd0;
                    r_count  <= 6'd0;
                    r_anyhit <= 1'b0;
                    r_status_q <= gnm_pkg::ST_OK;
                    r_cell   <= 8'(9'(i_cmd.row) * 9'(i_cmd.across) + 9'(i_cmd.col));
                end
                gnm_pkg::BS_CELL: begin
                    if (r_cmd.outside) r_status_q <= gnm_pkg::ST_OUTSIDE;
                    if (r_cmd.func == gnm_pkg::FUNC_QUERY) begin
                        r_cell <= w_nc[7:0];
                        if (!w_inb) r_nb <= r_nb + 4'd1;
                    end
                end
                gnm_pkg::BS_FILL: begin
                    r_n  <= w_fill;
                    r_i  <= 3'd0;
                    r_k  <= 3'd0;
                    r_rd <= 1'b0;
                    if (r_cmd.func == gnm_pkg::FUNC_ADD && w_fill >= 3'd4)
                        r_status_q <= gnm_pkg::ST_FULL;
                end
                gnm_pkg::BS_READ: begin
                    r_rd <= (r_i != r_n);
                    if (r_i != r_n) r_i <= r_i + 3'd1;
                    if (r_rd) begin
                        if (r_cmd.func == gnm_pkg::FUNC_REMOVE) begin
                            if (w_rdata != r_cmd.id) r_k <= r_k + 3'd1;
                        end else if (r_count != 6'(gnm_pkg::MAX_RESULTS)) begin
                            // Hold one hit back so its last flag is known.
                            if (r_anyhit) begin
                                o_found_id <= r_hit;
                                o_has_id   <= 1'b1;
                                o_status   <= gnm_pkg::ST_OK;
                                o_last     <= 1'b0;
                            end
                            r_hit    <= w_rdata;
                            r_anyhit <= 1'b1;
                            r_count  <= r_count + 6'd1;
                        end
                    end
                    if (r_i == r_n && !r_rd) begin
                        if (r_cmd.func == gnm_pkg::FUNC_REMOVE && r_k == r_n)
                            r_status_q <= gnm_pkg::ST_NOTFOUND;
                        r_nb <= r_nb + 4'd1;
                    end
                end
                gnm_pkg::BS_DONE: begin
                    o_last     <= 1'b1;
                    if (r_anyhit) begin
                        o_found_id <= r_hit;
                        o_has_id   <= 1'b1;
                        o_status   <= gnm_pkg::ST_OK;
                    end else begin
                        o_found_id <= r_cmd.id;
                        o_has_id   <= 1'b0;
                        o_status   <= r_status_q;
                    end
                end
                default: r_nb <= r_nb;
            endcase
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 6'(gnm_pkg::MAX_RESULTS)) else $error("too many hits");
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_has_id) |-> o_status == gnm_pkg::ST_OK)
        else $error("hit with bad status");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == gnm_pkg::BS_CELL) else $error("pop lost");
endmodule

// ----- hw/rtl/grid_neighbor_membership_table_top.sv -----
// ============================================================================
// grid_neighbor_membership_table_top - nine-cell area-of-interest table
// Front locates the cell, a one-entry queue decouples it from the back,
// which updates or walks the cell store and emits results.
// ============================================================================
//  channel | signals                                  | rule
//  --------+------------------------------------------+-------------------------
//  item in | i_start, o_busy, i_func..i_pos_y         | beat when start & !busy
//  result  | o_strobe, o_found_id..o_last             | one cycle, no stall
//  config  | psel penable pwrite paddr pwdata prdata  | APB, pready always high
//
// Order: after each accepted beat the front holds busy through the bit-serial
// division and the push, and takes no new beat until it is back in idle.
// The back finishes an outside or unused beat without touching the store; an
// add reads the fill count and then writes, a remove reads each stored id and
// writes back the rest, and a query steps past each neighbor off the grid and
// reads the fill count and then every stored id of each cell on it.
// Reset clears all fill counts at once through per-cell valid bits; the id
// RAM is not cleared. Results cannot be stalled; the front holds in its push
// state while the queue is full, so busy stays high then and while dividing.
module grid_neighbor_membership_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_member_id,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    output logic [15:0] o_found_id,
    output logic        o_has_id,
    output logic [1:0]  o_status,
    output logic        o_last,
    output logic        o_strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic signed [15:0] r_x_origin, r_y_origin;
    logic [15:0] r_cell_width, r_cell_height;
    logic [4:0]  r_cells_across, r_cells_down;
    logic        w_wr;
    logic [2:0]  w_idx;

    gnm_pkg::t_cmd w_cmd, r_q;
    logic        r_qv, w_push, w_pop, w_fbusy, w_idle;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin     <= '0;
            r_cell_width   <= 16'd1;
            r_cells_across <= 5'd16;
            r_y_origin     <= '0;
            r_cell_height  <= 16'd1;
            r_cells_down   <= 5'd16;
        end else if (w_wr) begin
            case (w_idx)
                gnm_pkg::REG_X_ORIGIN:     r_x_origin     <= pwdata[15:0];
                gnm_pkg::REG_CELL_WIDTH:   r_cell_width   <= pwdata[15:0];
                gnm_pkg::REG_CELLS_ACROSS: r_cells_across <= pwdata[4:0];
                gnm_pkg::REG_Y_ORIGIN:     r_y_origin     <= pwdata[15:0];
                gnm_pkg::REG_CELL_HEIGHT:  r_cell_height  <= pwdata[15:0];
                gnm_pkg::REG_CELLS_DOWN:   r_cells_down   <= pwdata[4:0];
                default:                   r_cells_down   <= r_cells_down;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            gnm_pkg::REG_X_ORIGIN:     prdata = 32'(unsigned'(r_x_origin));
            gnm_pkg::REG_CELL_WIDTH:   prdata = 32'(r_cell_width);
            gnm_pkg::REG_CELLS_ACROSS: prdata = 32'(r_cells_across);
            gnm_pkg::REG_Y_ORIGIN:     prdata = 32'(unsigned'(r_y_origin));
            gnm_pkg::REG_CELL_HEIGHT:  prdata = 32'(r_cell_height);
            gnm_pkg::REG_CELLS_DOWN:   prdata = 32'(r_cells_down);
            default:                   prdata = '0;
        endcase
    end

    gnm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_func(i_func), .i_member_id(i_member_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_x_origin(r_x_origin), .i_cell_width(r_cell_width),
        .i_cells_across(r_cells_across), .i_y_origin(r_y_origin),
        .i_cell_height(r_cell_height), .i_cells_down(r_cells_down),
        .i_q_full(r_qv), .o_busy(w_fbusy), .o_push(w_push), .o_cmd(w_cmd));

    // One-entry queue between the parts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
        end else if (w_push) begin
            r_qv <= 1'b1;
            r_q  <= w_cmd;
        end else if (w_pop) begin
            r_qv <= 1'b0;
        end
    end

    assign o_busy = w_fbusy;

    gnm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_qv), .i_cmd(r_q),
        .o_pop(w_pop), .o_idle(w_idle), .o_found_id(o_found_id),
        .o_has_id(o_has_id), .o_status(o_status), .o_last(o_last),
        .o_strobe(o_strobe));

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !r_qv) else $error("queue overrun");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_qv && w_idle)) else $error("pop of empty queue");
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_has_id) |-> o_last) else $error("echo not last");
endmodule

// ----- dv/tb_grid_neighbor_membership_table_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Neighbor membership table testbench
// Drives add, remove, no-op and neighbor-query beats through the command port,
// keeps its own copy of the cell lists and grid registers, and checks every
// result beat field by field against the predicted sequence.
// ----------------------------------------------------------------------------
module tb_grid_neighbor_membership_table_top;

    typedef struct packed {
        logic [15:0] id;
        logic        has;
        logic [1:0]  st;
        logic        last;
    } t_res;

    // Scoreboard: holds the grid model and the queue of expected result beats.
    class grid_table_board;
        int          xo, yo, cw, ch, nacross, ndown;
        logic [15:0] members [256][4];
        int          fill [256];
        t_res        pending [$];
        int          errors;

        function void set_reg(int idx, logic [31:0] v);
            case (idx)
                gnm_pkg::REG_X_ORIGIN:     xo = $signed(v[15:0]);
                gnm_pkg::REG_CELL_WIDTH:   cw = v[15:0];
                gnm_pkg::REG_CELLS_ACROSS: nacross = v[4:0];
                gnm_pkg::REG_Y_ORIGIN:     yo = $signed(v[15:0]);
                gnm_pkg::REG_CELL_HEIGHT:  ch = v[15:0];
                gnm_pkg::REG_CELLS_DOWN:   ndown = v[4:0];
                default: ;
            endcase
        endfunction

        function void push(logic [15:0] id, logic h, logic [1:0] s, logic l);
            t_res r;
            r.id = id; r.has = h; r.st = s; r.last = l;
            pending.insert(pending.size(), r);
        endfunction

        function void note_item(logic [1:0] f, logic [15:0] id, logic signed [15:0] px,
                                logic signed [15:0] py);
            int dx, dy, w, h, ac, dn, col, row, cidx, n, k, cnt, r, c, nc;
            dx = int'(px) - xo;
            dy = int'(py) - yo;
            w = (cw == 0) ? 1 : cw;
            h = (ch == 0) ? 1 : ch;
            ac = (nacross == 0) ? 1 : (nacross > 16 ? 16 : nacross);
            dn = (ndown == 0) ? 1 : (ndown > 16 ? 16 : ndown);
            if (dx < 0 || dy < 0 || dx / w >= ac || dy / h >= dn) begin
                push(id, 0, gnm_pkg::ST_OUTSIDE, 1);
                return;
            end
            col = dx / w; row = dy / h;
            cidx = row * ac + col;
            n = fill[cidx];
            case (f)
                gnm_pkg::FUNC_ADD: begin
                    if (n >= 4) begin
                        push(id, 0, gnm_pkg::ST_FULL, 1);
                    end else begin
                        members[cidx][n] = id;
                        fill[cidx] = n + 1;
                        push(id, 0, gnm_pkg::ST_OK, 1);
                    end
                end
                gnm_pkg::FUNC_REMOVE: begin
                    k = 0;
                    for (int i = 0; i < n; i++)
                        if (members[cidx][i] != id) begin
                            members[cidx][k] = members[cidx][i];
                            k++;
                        end
                    fill[cidx] = k;
                    push(id, 0, (k == n) ? gnm_pkg::ST_NOTFOUND : gnm_pkg::ST_OK, 1);
                end
                gnm_pkg::FUNC_QUERY: begin
                    cnt = 0;
                    for (int dr = 1; dr >= -1; dr--)
                        for (int dc = 1; dc >= -1; dc--) begin
                            r = row + dr; c = col + dc;
                            if (r < 0 || c < 0 || r >= dn || c >= ac) continue;
                            nc = r * ac + c;
                            for (int i = 0; i < fill[nc] && cnt < gnm_pkg::MAX_RESULTS;
                                 i++) begin
                                push(members[nc][i], 1, gnm_pkg::ST_OK, 0);
                                cnt++;
                            end
                        end
                    if (cnt == 0) push(id, 0, gnm_pkg::ST_OK, 1);
                    else pending[$].last = 1;
                end
                default: push(id, 0, gnm_pkg::ST_OK, 1);
            endcase
        endfunction

        function void check_beat(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat id=%h has=%b st=%0d last=%b",
                             got.id, got.has, got.st, got.last);
                return;
            end
            e = pending.pop_front();
            if (e != got) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp id=%h has=%b st=%0d last=%b, ",
                              "got id=%h has=%b st=%0d last=%b"},
                             e.id, e.has, e.st, e.last,
                             got.id, got.has, got.st, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic [1:0]  i_func = 0;
    logic [15:0] i_member_id = 0;
    logic signed [15:0] i_pos_x = 0;
    logic signed [15:0] i_pos_y = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    wire         o_busy, o_has_id, o_last, o_strobe, pready;
    wire  [15:0] o_found_id;
    wire  [1:0]  o_status;
    wire  [31:0] prdata;

    grid_table_board board;
    int          idle_pct;
    logic [15:0] id_pool [8];

    grid_neighbor_membership_table_top dut (.*);

    always #4 i_clk = ~i_clk;

    // Check each result beat at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && o_strobe) begin
            r.id = o_found_id; r.has = o_has_id; r.st = o_status; r.last = o_last;
            board.check_beat(r);
        end
    end

    // Write one register in a setup and an access cycle; mirror it in the model.
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, v);
    endtask

    // Present one item and hold start until the front is idle again; the next call
    // drops it (as does drain) or leaves it high when the next item follows without a gap.
    task automatic send_item(logic [1:0] f, logic [15:0] id, logic [15:0] px, logic [15:0] py);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1; i_func <= f; i_member_id <= id; i_pos_x <= px; i_pos_y <= py;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_item(f, id, px, py);
    endtask

    task automatic drain();
        i_start <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        // Let the back end settle before any register write.
        repeat (100) @(posedge i_clk);
    endtask

    // Random item aimed inside the grid most of the time, with a small id pool
    // so removes and repeated adds hit.
    task automatic random_item();
        int          ac, dn;
        logic [1:0]  f;
        logic [15:0] id, px, py;
        ac = (board.nacross == 0) ? 1 : (board.nacross > 16 ? 16 : board.nacross);
        dn = (board.ndown == 0) ? 1 : (board.ndown > 16 ? 16 : board.ndown);
        f = $urandom_range(99) < 40 ? gnm_pkg::FUNC_ADD :
            ($urandom_range(99) < 55 ? gnm_pkg::FUNC_QUERY :
            ($urandom_range(99) < 95 ? gnm_pkg::FUNC_REMOVE : gnm_pkg::FUNC_NOP));
        id = ($urandom_range(99) < 80) ? id_pool[$urandom_range(7)] : 16'($urandom);
        if ($urandom_range(99) < 90) begin
            px = 16'(board.xo + $urandom_range(ac * (board.cw ? board.cw : 1) - 1));
            py = 16'(board.yo + $urandom_range(dn * (board.ch ? board.ch : 1) - 1));
        end else begin
            px = 16'($urandom); py = 16'($urandom);
        end
        send_item(f, id, px, py);
    endtask

    initial begin
        board = new();
        board.xo = 0; board.cw = 1; board.nacross = 16;
        board.yo = 0; board.ch = 1; board.ndown = 16;
        for (int i = 0; i < 256; i++) board.fill[i] = 0;
        for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
        id_pool[0] = 16'h0000; id_pool[1] = 16'hFFFF;
        idle_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset grid (16x16 cells of size 1), extremes and corners.
        send_item(gnm_pkg::FUNC_QUERY, 16'hA5A5, 16'sd5, 16'sd5);
        for (int i = 0; i < 5; i++)
            send_item(gnm_pkg::FUNC_ADD, id_pool[i], 16'sd0, 16'sd0);
        send_item(gnm_pkg::FUNC_ADD, 16'h1234, 16'sd1, 16'sd1);
        send_item(gnm_pkg::FUNC_ADD, 16'hFFFF, 16'sd15, 16'sd15);
        send_item(gnm_pkg::FUNC_QUERY, 16'h0001, 16'sd0, 16'sd0);
        send_item(gnm_pkg::FUNC_QUERY, 16'h0002, 16'sd15, 16'sd15);
        send_item(gnm_pkg::FUNC_REMOVE, 16'h5555, 16'sd0, 16'sd0);
        send_item(gnm_pkg::FUNC_REMOVE, id_pool[1], 16'sd0, 16'sd0);
        send_item(gnm_pkg::FUNC_NOP, 16'h8001, 16'sd3, 16'sd3);
        send_item(gnm_pkg::FUNC_ADD, 16'h7777, -16'sd1, 16'sd0);
        send_item(gnm_pkg::FUNC_ADD, 16'h7777, 16'sd16, 16'sd0);
        send_item(gnm_pkg::FUNC_ADD, 16'h7777, 16'sh7FFF, 16'sh8000);
        send_item(gnm_pkg::FUNC_QUERY, 16'h0F0F, 16'sd0, 16'sd16);
        drain();

        // Full 3x3 block for a long query, then extreme and odd registers.
        for (int c = 0; c < 9; c++)
            for (int k = 0; k < 4; k++)
                if (board.fill[(4 + c / 3) * 16 + 4 + c % 3] < 4)
                    send_item(gnm_pkg::FUNC_ADD, 16'(c * 16 + k),
                              16'(4 + c % 3), 16'(4 + c / 3));
        send_item(gnm_pkg::FUNC_QUERY, 16'h0BAD, 16'sd5, 16'sd5);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(gnm_pkg::REG_X_ORIGIN, 32'hFFFF8000);
                    write_reg(gnm_pkg::REG_CELL_WIDTH, 32'hFFFF);
                    write_reg(gnm_pkg::REG_CELLS_ACROSS, 32'd1);
                    write_reg(gnm_pkg::REG_Y_ORIGIN, 32'h7FFF);
                    write_reg(gnm_pkg::REG_CELL_HEIGHT, 32'd0);
                    write_reg(gnm_pkg::REG_CELLS_DOWN, 32'd0);
                end
                1: begin
                    write_reg(gnm_pkg::REG_X_ORIGIN, 32'hFFFFFF00);
                    write_reg(gnm_pkg::REG_CELL_WIDTH, 32'd37);
                    write_reg(gnm_pkg::REG_CELLS_ACROSS, 32'd31);
                    write_reg(gnm_pkg::REG_Y_ORIGIN, 32'd100);
                    write_reg(gnm_pkg::REG_CELL_HEIGHT, 32'd5);
                    write_reg(gnm_pkg::REG_CELLS_DOWN, 32'd3);
                end
                2: begin
                    write_reg(gnm_pkg::REG_X_ORIGIN, 32'd0);
                    write_reg(gnm_pkg::REG_CELL_WIDTH, 32'd0);
                    write_reg(gnm_pkg::REG_CELLS_ACROSS, 32'd4);
                    write_reg(gnm_pkg::REG_Y_ORIGIN, 32'd0);
                    write_reg(gnm_pkg::REG_CELL_HEIGHT, 32'd2);
                    write_reg(gnm_pkg::REG_CELLS_DOWN, 32'd16);
                end
                3: begin
                    write_reg(gnm_pkg::REG_CELL_WIDTH, 32'd1000);
                    write_reg(gnm_pkg::REG_CELLS_ACROSS, 32'd16);
                    write_reg(gnm_pkg::REG_CELL_HEIGHT, 32'd300);
                    write_reg(gnm_pkg::REG_CELLS_DOWN, 32'd1);
                    write_reg(gnm_pkg::REG_X_ORIGIN, 32'hFFFF9000);
                end
                default: begin
                    write_reg(gnm_pkg::REG_CELL_WIDTH, 32'd3);
                    write_reg(gnm_pkg::REG_CELL_HEIGHT, 32'd3);
                    write_reg(gnm_pkg::REG_CELLS_ACROSS, 32'd2);
                    write_reg(gnm_pkg::REG_CELLS_DOWN, 32'd2);
                end
            endcase
            // Cycle sender idling: none, heavy, and mixed.
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 83 : 37);
            for (int n = 0; n < 42; n++) random_item();
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
